FILE: design/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the utf-8 stream decoder
// used by utf8d_decode, utf8d_emit and utf8_stream_decoder; no dependencies
package utf8d_pkg;

  // widths of the result fields
  localparam int unsigned CpW      = 21;
  localparam int unsigned QcntW    = 3;

  // substitution character and byte classes
  localparam logic [CpW-1:0] QMARK     = 21'h00003F;
  localparam logic [7:0]     ContMask  = 8'hC0;
  localparam logic [7:0]     ContCode  = 8'h80;
  localparam logic [7:0]     Lead2Mask = 8'h1F;
  localparam logic [7:0]     Lead3Mask = 8'h0F;
  localparam logic [7:0]     Lead4Mask = 8'h07;
  localparam logic [5:0]     PayMask   = 6'h3F;

  // results caused by one byte: replacement marks first, then an optional value
  typedef struct packed {
    logic [QcntW-1:0] n_qmark;
    logic             has_val;
    logic [CpW-1:0]   val_cp;
    logic             val_rep;
  } job_t;

endpackage

FILE: design/utf8d_decode.sv
// utf8d_decode: input register, sequence state and per-byte decode
// depends on utf8d_pkg; hands one job_t per byte that gives a result to utf8d_emit
module utf8d_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      latin1_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                in_byte_i,
  input  logic                      in_end_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output utf8d_pkg::job_t           job_o
);

  logic                       in_valid_q;
  logic [7:0]                 in_byte_q;
  logic                       in_end_q;
  logic [1:0]                 need_q, need_d;
  logic [1:0]                 held_q, held_d;
  logic [utf8d_pkg::CpW-1:0]  pv_q, pv_d;
  utf8d_pkg::job_t            job;
  logic                       res_any;
  logic                       move;
  logic                       cont;
  logic [1:0]                 held_inc;
  logic [utf8d_pkg::CpW-1:0]  pv_ext;
  logic [utf8d_pkg::QcntW-1:0] flush;

  // byte decode against the open sequence
  always_comb begin
    job      = '0;
    need_d   = need_q;
    held_d   = held_q;
    pv_d     = pv_q;
    cont     = (in_byte_q & utf8d_pkg::ContMask) == utf8d_pkg::ContCode;
    held_inc = held_q + 2'd1;
    pv_ext   = {pv_q[utf8d_pkg::CpW-7:0], in_byte_q[5:0] & utf8d_pkg::PayMask};
    flush    = (need_q != 2'd0) ? {1'b0, held_q} : '0;
    if (need_q != 2'd0 && cont) begin
      if (need_q == 2'd1) begin
        job.has_val = 1'b1;
        job.val_cp  = pv_ext;
        need_d      = '0;
        held_d      = '0;
        pv_d        = '0;
      end else begin
        need_d = need_q - 2'd1;
        held_d = held_inc;
        pv_d   = pv_ext;
        // stream end with the sequence still open
        if (in_end_q) begin
          job.n_qmark = {1'b0, held_inc};
          need_d      = '0;
          held_d      = '0;
          pv_d        = '0;
        end
      end
    end else begin
      need_d      = '0;
      held_d      = '0;
      pv_d        = '0;
      job.n_qmark = flush;
      case (in_byte_q) inside
        [8'h00:8'h7F]: begin
          job.has_val = 1'b1;
          job.val_cp  = {{(utf8d_pkg::CpW-8){1'b0}}, in_byte_q};
        end
        [8'hC0:8'hDF]: begin
          need_d = 2'd1;
          held_d = 2'd1;
          pv_d   = {{(utf8d_pkg::CpW-8){1'b0}}, in_byte_q & utf8d_pkg::Lead2Mask};
        end
        [8'hE0:8'hEF]: begin
          need_d = 2'd2;
          held_d = 2'd1;
          pv_d   = {{(utf8d_pkg::CpW-8){1'b0}}, in_byte_q & utf8d_pkg::Lead3Mask};
        end
        [8'hF0:8'hF7]: begin
          need_d = 2'd3;
          held_d = 2'd1;
          pv_d   = {{(utf8d_pkg::CpW-8){1'b0}}, in_byte_q & utf8d_pkg::Lead4Mask};
        end
        default: begin
          // stray continuation or invalid lead
          job.n_qmark = flush + 3'd1;
        end
      endcase
      // a lead opened by the final byte is flushed at once
      if (in_end_q && need_d != 2'd0) begin
        job.n_qmark = flush + 3'd1;
        need_d      = '0;
        held_d      = '0;
        pv_d        = '0;
      end
    end
    // latin-1 range limit
    if (job.has_val && latin1_i && (|job.val_cp[utf8d_pkg::CpW-1:8])) begin
      job.val_cp  = utf8d_pkg::QMARK;
      job.val_rep = 1'b1;
    end
  end

  // handoff: bytes with no result retire without waiting on the output side
  assign res_any     = (job.n_qmark != '0) || job.has_val;
  assign move        = in_valid_q && (job_ready_i || !res_any);
  assign in_ready_o  = !in_valid_q || move;
  assign job_valid_o = in_valid_q && res_any;
  assign job_o       = job;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_end_q  <= in_end_i;
    end
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= '0;
      held_q <= '0;
      pv_q   <= '0;
    end else if (move) begin
      need_q <= need_d;
      held_q <= held_d;
      pv_q   <= pv_d;
    end
  end

  // open sequence holds its lead and fits in four bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q != 2'd0) |-> (held_q != 2'd0) && ({1'b0, held_q} + {1'b0, need_q} <= 3'd4))
    else $error("open sequence count out of range");

  // closed sequence leaves no gathered payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q == 2'd0) |-> (held_q == 2'd0) && (pv_q == '0))
    else $error("closed sequence left state behind");

  // never more than four results per byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> ({1'b0, job.n_qmark} + {3'b0, job.has_val} <= 4'd4))
    else $error("too many results for one byte");

endmodule

FILE: design/utf8d_emit.sv
// utf8d_emit: result register that plays out one job_t as result transactions
// depends on utf8d_pkg; fed by utf8d_decode
module utf8d_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  input  utf8d_pkg::job_t           job_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [utf8d_pkg::CpW-1:0] out_cp_o,
  output logic                      out_rep_o,
  output logic                      out_last_o
);

  logic [utf8d_pkg::QcntW-1:0] rem_q;
  logic                        has_val_q;
  logic [utf8d_pkg::CpW-1:0]   cp_q;
  logic                        rep_q;
  logic                        fire;
  logic                        load;

  // current result: replacement marks first, value last
  assign out_valid_o = (rem_q != '0) || has_val_q;
  assign out_last_o  = (rem_q == '0) || (rem_q == 3'd1 && !has_val_q);
  assign out_cp_o    = (rem_q != '0) ? utf8d_pkg::QMARK : cp_q;
  assign out_rep_o   = (rem_q != '0) ? 1'b1 : rep_q;

  assign fire        = out_valid_o && out_ready_i;
  assign job_ready_o = !out_valid_o || (fire && out_last_o);
  assign load        = job_valid_i && job_ready_o;

  // job counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      has_val_q <= 1'b0;
    end else if (load) begin
      rem_q     <= job_i.n_qmark;
      has_val_q <= job_i.has_val;
    end else if (fire) begin
      if (rem_q != '0) begin
        rem_q <= rem_q - 3'd1;
      end else begin
        has_val_q <= 1'b0;
      end
    end
  end

  // value payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q  <= job_i.val_cp;
      rep_q <= job_i.val_rep;
    end
  end

  // a decoded value is always the final result of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rep_o) |-> out_last_o)
    else $error("decoded value not marked last");

  // every replacement carries the question mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rep_o) |-> (out_cp_o == utf8d_pkg::QMARK))
    else $error("replacement with wrong codepoint");

  // a loaded job shows up on the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("loaded job not presented");

endmodule

FILE: design/utf8_stream_decoder.sv
// utf8_stream_decoder: top level of the utf-8 byte stream to codepoint decoder
// depends on utf8d_pkg, utf8d_decode and utf8d_emit
//
//   channel  | direction | tdata                 | tuser    | tlast
//   s_axis   | in        | [7:0] data_byte       | -        | stream_end
//   m_axis   | out       | [20:0] codepoint      | replaced | run_last
//   cfg      | in        | cfg_wdata_i = latin1_only (reset 1), written on cfg_we_i
//
// one byte accepted per cycle unless held back by the result register; results move
// on from the input register into the result register; a byte with several results
// holds the result register until its last is taken, so output stalls or multi-result
// bytes back up into the input register; no-result bytes never touch the result register
// asynchronous active-low reset; no clearing pass, input ready as soon as reset releases
module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] codepoint, [23:21] zero
  output logic        m_axis_tuser,   // replaced
  output logic        m_axis_tlast    // run_last
);

  logic                      latin1_q;
  logic                      job_valid;
  logic                      job_ready;
  utf8d_pkg::job_t           job;
  logic [utf8d_pkg::CpW-1:0] out_cp;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latin1_q <= 1'b1;
    end else if (cfg_we_i) begin
      latin1_q <= cfg_wdata_i;
    end
  end

  // decode stage
  utf8d_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .latin1_i    (latin1_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // result stage
  utf8d_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_cp_o    (out_cp),
    .out_rep_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_cp};

endmodule

FILE: bench/utf8_stream_decoder_tb.sv
// utf8_stream_decoder_tb: self-checking bench for the utf-8 stream decoder
// drives bytes on s_axis, checks codepoints on m_axis against an in-bench decoder
// depends on utf8d_pkg and utf8_stream_decoder
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;

  localparam int CycleLimit = 100000;
  localparam int NumRows    = 25;

  // one decoded result as it leaves the block
  typedef struct packed {
    logic [utf8d_pkg::CpW-1:0] cp;
    logic                      rep;
    logic                      last;
  } cp_res_t;

  // directed byte; typed rows carry their single result written out
  typedef struct packed {
    logic [7:0]                b;
    logic                      e;
    logic                      typed;
    logic [utf8d_pkg::CpW-1:0] cp;
    logic                      rep;
  } dir_row_t;

  localparam dir_row_t DirTab [NumRows] = '{
    '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},         // lowest ascii
    '{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0},         // highest ascii
    '{8'h80, 1'b0, 1'b1, utf8d_pkg::QMARK, 1'b1},   // stray continuation, low end
    '{8'hBF, 1'b0, 1'b1, utf8d_pkg::QMARK, 1'b1},   // stray continuation, high end
    '{8'hF8, 1'b0, 1'b1, utf8d_pkg::QMARK, 1'b1},   // invalid lead, low end
    '{8'hFF, 1'b0, 1'b1, utf8d_pkg::QMARK, 1'b1},   // invalid lead, high end
    '{8'hC3, 1'b0, 1'b0, 21'h0, 1'b0},              // two-byte sequence, fits latin-1
    '{8'hA9, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hC4, 1'b0, 1'b0, 21'h0, 1'b0},              // two-byte sequence above latin-1
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 21'h0, 1'b0},              // three-byte sequence
    '{8'h82, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hAC, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 21'h0, 1'b0},              // four-byte sequence
    '{8'h8F, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 21'h0, 1'b0},              // sequence broken by an ascii byte
    '{8'h82, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hF0, 1'b1, 1'b1, utf8d_pkg::QMARK, 1'b1},   // stream end on a fresh lead
    '{8'hC0, 1'b0, 1'b0, 21'h0, 1'b0},              // overlong form passes through
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hE0, 1'b0, 1'b0, 21'h0, 1'b0},              // stream end inside a sequence
    '{8'h80, 1'b1, 1'b0, 21'h0, 1'b0}
  };

  // block ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // decoder state mirrored by the bench
  bit                        latin1 = 1'b1;
  logic [1:0]                need   = 2'd0;
  logic [1:0]                held   = 2'd0;
  logic [utf8d_pkg::CpW-1:0] acc    = '0;

  cp_res_t cp_exp_q [$];  // results still owed by the block
  cp_res_t step_q   [$];  // results of the byte just taken

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  bit rx_hold_req  = 1'b0;
  int rx_hold_left = 0;
  int n_sent       = 0;
  int n_checked    = 0;
  int n_errors     = 0;
  int cycle_cnt    = 0;

  utf8_stream_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               cp_exp_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= 30) begin
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
    end
  endtask

  // decoder model: one byte in, zero to four results in step_q
  task automatic put_cp(input logic [utf8d_pkg::CpW-1:0] cp, input logic rep);
    step_q.push_back(cp_res_t'{cp, rep, 1'b0});
  endtask

  task automatic put_value(input logic [utf8d_pkg::CpW-1:0] cp);
    if (latin1 && cp > 21'h0000FF) begin
      put_cp(utf8d_pkg::QMARK, 1'b1);
    end else begin
      put_cp(cp, 1'b0);
    end
  endtask

  task automatic flush_open();
    for (int i = 0; i < held; i++) put_cp(utf8d_pkg::QMARK, 1'b1);
    need = 2'd0;
    held = 2'd0;
    acc  = '0;
  endtask

  task automatic take_lead(input logic [7:0] b);
    if (b < 8'h80) begin
      put_value({13'd0, b});
    end else if (b < 8'hC0 || b >= 8'hF8) begin
      put_cp(utf8d_pkg::QMARK, 1'b1);
    end else begin
      if (b < 8'hE0) begin
        acc  = {13'd0, b & utf8d_pkg::Lead2Mask};
        need = 2'd1;
      end else if (b < 8'hF0) begin
        acc  = {13'd0, b & utf8d_pkg::Lead3Mask};
        need = 2'd2;
      end else begin
        acc  = {13'd0, b & utf8d_pkg::Lead4Mask};
        need = 2'd3;
      end
      held = 2'd1;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic e);
    cp_res_t tail;
    step_q.delete();
    if (need != 2'd0) begin
      if ((b & utf8d_pkg::ContMask) == utf8d_pkg::ContCode) begin
        // continuation adds six payload bits
        acc  = {acc[utf8d_pkg::CpW-7:0], b[5:0] & utf8d_pkg::PayMask};
        held = held + 2'd1;
        need = need - 2'd1;
        if (need == 2'd0) begin
          put_value(acc);
          held = 2'd0;
          acc  = '0;
        end
      end else begin
        // broken sequence, then the byte starts over as a lead
        flush_open();
        take_lead(b);
      end
    end else begin
      take_lead(b);
    end
    if (e && need != 2'd0) flush_open();
    if (step_q.size() != 0) begin
      tail = step_q.pop_back();
      tail.last = 1'b1;
      step_q.push_back(tail);
    end
  endtask

  // one s_axis transaction with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= e;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, e);
    while (step_q.size() != 0) cp_exp_q.push_back(step_q.pop_front());
    n_sent++;
    @(negedge clk_i);
  endtask

  // stop sending until every owed result has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (cp_exp_q.size() != 0);
  endtask

  task automatic write_latin1(input bit value);
    drain_results();
    repeat (6) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    latin1 = value;
  endtask

  function automatic logic [7:0] make_lead(input int len);
    logic [31:0] r;
    r = $urandom;
    case (len)
      1:       make_lead = {1'b0, r[6:0]};
      2:       make_lead = {3'b110, r[4:0]};
      3:       make_lead = {4'b1110, r[3:0]};
      default: make_lead = {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] make_cont();
    logic [31:0] r;
    r = $urandom;
    make_cont = {2'b10, r[5:0]};
  endfunction

  function automatic logic pick_end();
    pick_end = ($urandom_range(39) == 0);
  endfunction

  // mostly well-formed characters, mixed with broken ones, early stream ends and noise
  task automatic random_phase(input int n_items);
    int          stop_at;
    int          kind;
    int          len;
    int          keep;
    logic [7:0]  brk;
    logic [31:0] r;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = $urandom_range(4, 1);
        send_byte(make_lead(len), pick_end());
        for (int i = 1; i < len; i++) send_byte(make_cont(), pick_end());
      end else if (kind < 85) begin
        len  = $urandom_range(4, 2);
        keep = $urandom_range(len - 2, 0);
        r    = $urandom;
        brk  = r[7:0];
        if (brk[7:6] == 2'b10) brk[6] = 1'b1;
        send_byte(make_lead(len), 1'b0);
        for (int i = 0; i < keep; i++) send_byte(make_cont(), 1'b0);
        send_byte(brk, pick_end());
      end else if (kind < 95) begin
        len  = $urandom_range(4, 2);
        keep = $urandom_range(len - 2, 0);
        send_byte(make_lead(len), keep == 0);
        for (int i = 0; i < keep; i++) send_byte(make_cont(), i == keep - 1);
      end else begin
        r = $urandom;
        send_byte(r[7:0], pick_end());
      end
    end
  endtask

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = 80;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // m_axis transaction checker
  always @(posedge clk_i) begin
    cp_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_checked++;
      if (cp_exp_q.size() == 0) begin
        report_mismatch("unexpected result", {8'd0, m_axis_tdata}, 32'd0);
      end else begin
        want = cp_exp_q.pop_front();
        if (m_axis_tdata !== {3'b000, want.cp})
          report_mismatch("codepoint", {8'd0, m_axis_tdata}, {11'd0, want.cp});
        if (m_axis_tuser !== want.rep)
          report_mismatch("replaced", {31'd0, m_axis_tuser}, {31'd0, want.rep});
        if (m_axis_tlast !== want.last)
          report_mismatch("run_last", {31'd0, m_axis_tlast}, {31'd0, want.last});
      end
    end
  end

  // stimulus
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed bytes at reset setting, no idling
    for (int i = 0; i < NumRows; i++) begin
      send_byte(DirTab[i].b, DirTab[i].e);
      if (DirTab[i].typed) begin
        void'(cp_exp_q.pop_back());
        cp_exp_q.push_back(cp_res_t'{DirTab[i].cp, DirTab[i].rep, 1'b1});
      end
    end

    // full range, slow receiver
    write_latin1(1'b0);
    tx_idle_pct = 16;
    rx_idle_pct = 74;
    random_phase(60);

    // latin-1, slow sender
    write_latin1(1'b1);
    tx_idle_pct = 74;
    rx_idle_pct = 16;
    random_phase(60);

    // full range, back to back
    write_latin1(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(30);

    // long receiver hold-off while bytes keep coming
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    rx_hold_req = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < 24; i++) send_byte(make_lead($urandom_range(4, 1)), 1'b0);

    // sender pause until the block is empty
    drain_results();
    random_phase(30);

    s_axis_tvalid <= 1'b0;
    while (cp_exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d bytes (%0d directed) with latin-1 on and off, %0d results checked",
             n_sent, NumRows, n_checked);
    $display("stalls on both sides, a long output hold-off and back-to-back streams");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/utf8d_pkg.sv
design/utf8d_decode.sv
design/utf8d_emit.sv
design/utf8_stream_decoder.sv
bench/utf8_stream_decoder_tb.sv
